### rtl/core/scta_pkg.sv
// Shared widths, key codes, modifier types and layout tables for the scan code translator.
`timescale 1ns / 1ps
package scta_pkg;

	localparam int BYTE_W = 8;
	localparam int CODE_W = 7;
	localparam int CHAR_W = 7;

	localparam logic [CODE_W-1:0] CODE_LSHIFT = 7'h2A;
	localparam logic [CODE_W-1:0] CODE_RSHIFT = 7'h36;
	localparam logic [CODE_W-1:0] CODE_CTRL   = 7'h1D;
	localparam logic [CODE_W-1:0] CODE_ALT    = 7'h38;
	localparam logic [CODE_W-1:0] CODE_CAPS   = 7'h3A;
	localparam logic [CODE_W-1:0] CAPS_LO     = 7'd16;
	localparam logic [CODE_W-1:0] CAPS_HI     = 7'd50;

	typedef struct packed {
		logic shift;
		logic ctrl;
		logic alt;
		logic caps;
	} mod_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ascii_char;
		logic              ctrl_held;
		logic              alt_held;
	} char_beat_t;

	function automatic logic [CHAR_W-1:0] lower_char(input logic [CODE_W-1:0] code);
		logic [CHAR_W-1:0] ch;
		case (code)
			7'd1:    ch = 7'h1B;
			7'd2:    ch = 7'h31;
			7'd3:    ch = 7'h32;
			7'd4:    ch = 7'h33;
			7'd5:    ch = 7'h34;
			7'd6:    ch = 7'h35;
			7'd7:    ch = 7'h36;
			7'd8:    ch = 7'h37;
			7'd9:    ch = 7'h38;
			7'd10:   ch = 7'h39;
			7'd11:   ch = 7'h30;
			7'd12:   ch = 7'h2D;
			7'd13:   ch = 7'h3D;
			7'd14:   ch = 7'h08;
			7'd15:   ch = 7'h09;
			7'd16:   ch = 7'h71;
			7'd17:   ch = 7'h77;
			7'd18:   ch = 7'h65;
			7'd19:   ch = 7'h72;
			7'd20:   ch = 7'h74;
			7'd21:   ch = 7'h79;
			7'd22:   ch = 7'h75;
			7'd23:   ch = 7'h69;
			7'd24:   ch = 7'h6F;
			7'd25:   ch = 7'h70;
			7'd26:   ch = 7'h5B;
			7'd27:   ch = 7'h5D;
			7'd28:   ch = 7'h0A;
			7'd30:   ch = 7'h61;
			7'd31:   ch = 7'h73;
			7'd32:   ch = 7'h64;
			7'd33:   ch = 7'h66;
			7'd34:   ch = 7'h67;
			7'd35:   ch = 7'h68;
			7'd36:   ch = 7'h6A;
			7'd37:   ch = 7'h6B;
			7'd38:   ch = 7'h6C;
			7'd39:   ch = 7'h3B;
			7'd40:   ch = 7'h27;
			7'd41:   ch = 7'h60;
			7'd43:   ch = 7'h5C;
			7'd44:   ch = 7'h7A;
			7'd45:   ch = 7'h78;
			7'd46:   ch = 7'h63;
			7'd47:   ch = 7'h76;
			7'd48:   ch = 7'h62;
			7'd49:   ch = 7'h6E;
			7'd50:   ch = 7'h6D;
			7'd51:   ch = 7'h2C;
			7'd52:   ch = 7'h2E;
			7'd53:   ch = 7'h2F;
			7'd55:   ch = 7'h2A;
			7'd57:   ch = 7'h20;
			7'd71:   ch = 7'h37;
			7'd72:   ch = 7'h38;
			7'd73:   ch = 7'h39;
			7'd74:   ch = 7'h2D;
			7'd75:   ch = 7'h34;
			7'd76:   ch = 7'h35;
			7'd77:   ch = 7'h36;
			7'd78:   ch = 7'h2B;
			7'd79:   ch = 7'h31;
			7'd80:   ch = 7'h32;
			7'd81:   ch = 7'h33;
			7'd82:   ch = 7'h30;
			7'd83:   ch = 7'h2E;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

	// Shifted layout: only the entries that differ from the lowercase one are listed.
	function automatic logic [CHAR_W-1:0] upper_char(input logic [CODE_W-1:0] code);
		logic [CHAR_W-1:0] ch;
		case (code)
			7'd2:    ch = 7'h21;
			7'd3:    ch = 7'h40;
			7'd4:    ch = 7'h23;
			7'd5:    ch = 7'h24;
			7'd6:    ch = 7'h25;
			7'd7:    ch = 7'h5E;
			7'd8:    ch = 7'h26;
			7'd9:    ch = 7'h2A;
			7'd10:   ch = 7'h28;
			7'd11:   ch = 7'h29;
			7'd12:   ch = 7'h5F;
			7'd13:   ch = 7'h2B;
			7'd16:   ch = 7'h51;
			7'd17:   ch = 7'h57;
			7'd18:   ch = 7'h45;
			7'd19:   ch = 7'h52;
			7'd20:   ch = 7'h54;
			7'd21:   ch = 7'h59;
			7'd22:   ch = 7'h55;
			7'd23:   ch = 7'h49;
			7'd24:   ch = 7'h4F;
			7'd25:   ch = 7'h50;
			7'd26:   ch = 7'h7B;
			7'd27:   ch = 7'h7D;
			7'd30:   ch = 7'h41;
			7'd31:   ch = 7'h53;
			7'd32:   ch = 7'h44;
			7'd33:   ch = 7'h46;
			7'd34:   ch = 7'h47;
			7'd35:   ch = 7'h48;
			7'd36:   ch = 7'h4A;
			7'd37:   ch = 7'h4B;
			7'd38:   ch = 7'h4C;
			7'd39:   ch = 7'h3A;
			7'd40:   ch = 7'h22;
			7'd41:   ch = 7'h7E;
			7'd43:   ch = 7'h7C;
			7'd44:   ch = 7'h5A;
			7'd45:   ch = 7'h58;
			7'd46:   ch = 7'h43;
			7'd47:   ch = 7'h56;
			7'd48:   ch = 7'h42;
			7'd49:   ch = 7'h4E;
			7'd50:   ch = 7'h4D;
			7'd51:   ch = 7'h3C;
			7'd52:   ch = 7'h3E;
			7'd53:   ch = 7'h3F;
			default: ch = lower_char(code);
		endcase
		return ch;
	endfunction

endpackage

### rtl/core/scta_scan_if.sv
// Channel carrying received scan code bytes.
`timescale 1ns / 1ps
interface scta_scan_if
	import scta_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] scan_byte;

	modport source(output valid, output scan_byte, input ready);
	modport sink(input valid, input scan_byte, output ready);
endinterface

### rtl/core/scta_char_if.sv
// Channel carrying translated characters with the ctrl and alt flags.
`timescale 1ns / 1ps
interface scta_char_if
	import scta_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ascii_char;
	logic              ctrl_held;
	logic              alt_held;

	modport source(output valid, output ascii_char, output ctrl_held, output alt_held,
		input ready);
	modport sink(input valid, input ascii_char, input ctrl_held, input alt_held,
		output ready);
endinterface

### rtl/core/scancode_to_ascii_translator_core.sv
// Top level of the scan code set 1 to ASCII translator.
`timescale 1ns / 1ps
// Takes one scan code set 1 byte per beat and returns at most one US layout ASCII
// character per byte, tagged with the ctrl and alt flags held at that moment. Releases
// and modifier presses (shift, ctrl, alt, caps lock) only update the modifier flags;
// unmapped keys give nothing. A new byte is accepted every cycle in which the input
// register is empty or its byte retires; the decode and the table lookup run on the byte
// held there, and its character goes to the result register as that byte retires. Throughput
// is set by the result register alone: while it holds an untaken character, a byte that
// yields a character waits in the input register, and bytes that yield none still retire.
module scancode_to_ascii_translator_core
	import scta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	scta_scan_if.sink   scan_in,
	scta_char_if.source char_out
);
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              retire;
	logic              emit;
	logic              out_free;
	mod_t              mod_q;
	mod_t              mod_next;
	char_beat_t        beat;

	// Retire the staged byte unless its character finds the result register occupied.
	assign retire = valid_s1 && (!emit || out_free);

	scta_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan_in  (scan_in),
		.retire   (retire),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	scta_xlate u_xlate (
		.byte_s1  (byte_s1),
		.mod_cur  (mod_q),
		.mod_next (mod_next),
		.emit     (emit),
		.beat     (beat)
	);

	scta_mod_state u_mod_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.retire   (retire),
		.mod_next (mod_next),
		.mod_q    (mod_q)
	);

	scta_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (retire && emit),
		.beat     (beat),
		.free     (out_free),
		.char_out (char_out)
	);
endmodule

### rtl/core/scta_in_reg.sv
// Input register stage: captures one scan byte beat and holds it until it retires.
`timescale 1ns / 1ps
module scta_in_reg
	import scta_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	scta_scan_if.sink         scan_in,
	input  logic              retire,
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);
	logic take;

	assign scan_in.ready = !valid_s1 || retire;
	assign take          = scan_in.valid && scan_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= scan_in.scan_byte;
		end
	end
endmodule

### rtl/core/scta_xlate.sv
// Decode of one scan byte: next modifier flags, table select and lookup.
`timescale 1ns / 1ps
module scta_xlate
	import scta_pkg::*;
(
	input  logic [BYTE_W-1:0] byte_s1,
	input  mod_t              mod_cur,
	output mod_t              mod_next,
	output logic              emit,
	output char_beat_t        beat
);
	logic [CODE_W-1:0] code;
	logic              release_key;
	logic              is_mod;
	logic              in_range;
	logic              use_upper;
	logic [CHAR_W-1:0] ch;

	assign code        = byte_s1[CODE_W-1:0];
	assign release_key = byte_s1[BYTE_W-1];
	assign is_mod      = code inside {CODE_LSHIFT, CODE_RSHIFT, CODE_CTRL, CODE_ALT, CODE_CAPS};
	assign in_range    = code inside {[CAPS_LO:CAPS_HI]};
	// Caps lock flips the shift sense only for codes 16 to 50: the letter rows, punctuation on them included.
	assign use_upper   = mod_cur.shift ^ (mod_cur.caps && in_range);
	assign ch          = use_upper ? upper_char(code) : lower_char(code);

	always_comb begin
		mod_next = mod_cur;
		if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
			mod_next.shift = !release_key;
		end else if (code == CODE_CTRL) begin
			mod_next.ctrl = !release_key;
		end else if (code == CODE_ALT) begin
			mod_next.alt = !release_key;
		end else if (code == CODE_CAPS && !release_key) begin
			mod_next.caps = !mod_cur.caps;
		end
	end

	assign emit            = !release_key && !is_mod && (ch != '0);
	assign beat.ascii_char = ch;
	assign beat.ctrl_held  = mod_cur.ctrl;
	assign beat.alt_held   = mod_cur.alt;
endmodule

### rtl/core/scta_mod_state.sv
// Modifier flag registers: shift, ctrl, alt held and caps lock toggle.
`timescale 1ns / 1ps
module scta_mod_state
	import scta_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic retire,
	input  mod_t mod_next,
	output mod_t mod_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= '0;
		end else if (retire) begin
			mod_q <= mod_next;
		end
	end
endmodule

### rtl/core/scta_out_reg.sv
// Result register: holds one character beat until the sink takes it.
`timescale 1ns / 1ps
module scta_out_reg
	import scta_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  char_beat_t  beat,
	output logic        free,
	scta_char_if.source char_out
);
	logic       valid_q;
	char_beat_t beat_q;

	assign free = !valid_q || char_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (char_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_q <= beat;
		end
	end

	assign char_out.valid      = valid_q;
	assign char_out.ascii_char = beat_q.ascii_char;
	assign char_out.ctrl_held  = beat_q.ctrl_held;
	assign char_out.alt_held   = beat_q.alt_held;
endmodule
